>>> rtl/core/rfat_pkg.sv
// shared types, constants and coefficient tables for the relay autotuner
// no dependencies
package rfat_pkg;

   localparam int SampleWidthDef  = 16;
   localparam int GainFracBitsDef = 16;
   localparam int TotalWidth      = 40;
   localparam int GainWidth       = 32;
   localparam int TimeWidth       = 32;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_TUNING  = 2'd1;
   localparam logic [1:0] ST_DONE    = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   localparam logic [2:0] CSR_TARGET  = 3'd0;
   localparam logic [2:0] CSR_HYST    = 3'd1;
   localparam logic [2:0] CSR_DHIGH   = 3'd2;
   localparam logic [2:0] CSR_DLOW    = 3'd3;
   localparam logic [2:0] CSR_RULE    = 3'd4;
   localparam logic [2:0] CSR_CYCLES  = 3'd5;
   localparam logic [2:0] CSR_TIMEOUT = 3'd6;

   // divider request: 64-bit dividend over 40-bit divisor
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [39:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [39:0] remainder;
   } div_rsp_type;

   function automatic logic [23:0] rule_kc(input logic [1:0] r);
      case (r)
         2'd0: rule_kc = 24'd12816849;
         2'd1: rule_kc = 24'd14952990;
         2'd2: rule_kc = 24'd7049267;
         default: rule_kc = 24'd4272283;
      endcase
   endfunction

   function automatic logic [11:0] rule_ki(input logic [1:0] r);
      rule_ki = (r == 2'd1) ? 12'd2500 : 12'd2000;
   endfunction

   function automatic logic [5:0] rule_tdn(input logic [1:0] r);
      case (r)
         2'd0: rule_tdn = 6'd1;
         2'd1: rule_tdn = 6'd3;
         default: rule_tdn = 6'd33;
      endcase
   endfunction

   function automatic logic [16:0] rule_tdd(input logic [1:0] r);
      case (r)
         2'd0: rule_tdd = 17'd8000;
         2'd1: rule_tdd = 17'd20000;
         default: rule_tdd = 17'd100000;
      endcase
   endfunction

endpackage

>>> rtl/core/rfat_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on rfat_pkg
module rfat_div
   import rfat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [40:0] rem_ff, rem_in;
   logic [39:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [40:0] shifted;
   logic [40:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[39:0], quo_ff[63]};
      diff    = shifted - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[40]) begin
            rem_in = diff;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[39:0];

endmodule

>>> rtl/core/relay_feedback_pid_autotuner.sv
// top level of the relay feedback autotuner: relay tracking, sequencer, shared divider
// depends on rfat_pkg and rfat_div
//
// Each req beat is either a start command (tuser = 1) or a measured sample with a
// millisecond time stamp. While tuning, the block drives a hysteretic relay around
// target_level, tracks peak and trough, and on every low-to-high switch computes
// per-cycle Kp, Ki and Kd from the relay and sample amplitudes with the selected
// rule; the first cycle is skipped. After cycles_wanted cycles it reports the
// averaged gains (unsigned Q16.16, saturating). Every req beat gives one rsp beat.
// A beat with no switch goes through S_EVAL to S_OUT and waits for the rsp handshake;
// a low-to-high switch runs the shared serial divider up to 7 times (Kp, Ki, Kd
// quotient, Kd remainder term, three averages). Multiplies are at most 40x24, 32x32
// and 32x12 bits, each registered.
module relay_feedback_pid_autotuner
   import rfat_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SampleWidthDef,
   parameter int GAIN_FRAC_BITS = GainFracBitsDef
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [((SAMPLE_WIDTH+32+7)/8)*8-1:0] req_tdata, // sample, time_ms
   input  logic                    req_tuser,  // func
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [((SAMPLE_WIDTH+99+7)/8)*8-1:0] rsp_tdata,
      // drive(SAMPLE_WIDTH) status gains_valid kp ki kd, padded
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_wdata
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int SHIFT = 24 - GAIN_FRAC_BITS;
   localparam int RSP_W = ((SW + 99 + 7) / 8) * 8;

   localparam logic [3:0] S_IDLE = 4'd0, S_EVAL = 4'd1, S_KP = 4'd2, S_KPW = 4'd3,
      S_KI = 4'd4, S_KIW = 4'd5, S_KD = 4'd6, S_KDW = 4'd7, S_KR = 4'd8, S_KRW = 4'd9,
      S_ACC = 4'd10, S_AVG = 4'd11, S_AVGW = 4'd12, S_OUT = 4'd13;

   // configuration
   logic signed [SW-1:0] target_ff, dhigh_ff, dlow_ff;
   logic [SW-2:0] hyst_ff;
   logic [1:0]    rule_ff;
   logic [7:0]    cycw_ff;
   logic [31:0]   tlim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0; hyst_ff <= '0; dhigh_ff <= '0; dlow_ff <= '0;
         rule_ff <= '0; cycw_ff <= 8'd1; tlim_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET:  target_ff <= csr_wdata[SW-1:0];
            CSR_HYST:    hyst_ff   <= csr_wdata[SW-2:0];
            CSR_DHIGH:   dhigh_ff  <= csr_wdata[SW-1:0];
            CSR_DLOW:    dlow_ff   <= csr_wdata[SW-1:0];
            CSR_RULE:    rule_ff   <= csr_wdata[1:0];
            CSR_CYCLES:  cycw_ff   <= csr_wdata[7:0];
            CSR_TIMEOUT: tlim_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // run state
   logic [3:0]  st_ff, st_in;
   logic [1:0]  run_ff, run_in;
   logic        relay_ff, relay_in;
   logic [31:0] last_ff, last_in;
   logic signed [SW-1:0] pkh_ff, pkh_in, pkl_ff, pkl_in;
   logic [7:0]  cyc_ff, cyc_in, smp_ff, smp_in;
   logic [39:0] kpt_ff, kpt_in, kit_ff, kit_in, kdt_ff, kdt_in;
   // working registers
   logic        func_ff, func_in;
   logic signed [SW-1:0] s_ff, s_in;
   logic [31:0] now_ff, now_in, el_ff, el_in;
   logic [SW:0] amp_ff, amp_in;
   logic [31:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [31:0] q_ff, q_in;
   logic        add_ff, add_in;
   logic [1:0]  avg_ff, avg_in;
   logic        gv_ff, gv_in;
   logic [31:0] gkp_ff, gkp_in, gki_ff, gki_in, gkd_ff, gkd_in;
   logic signed [SW-1:0] drv_ff, drv_in;
   logic        ov_ff, ov_in;

   div_req_type dreq;
   div_rsp_type drsp;

   rfat_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic signed [SW:0] span;
   logic signed [SW:0] hi_th, lo_th;
   logic [63:0] dq;
   logic [31:0] dq_sat;
   logic [63:0] prod;
   logic [39:0] tsel;

   assign span  = {dhigh_ff[SW-1], dhigh_ff} - {dlow_ff[SW-1], dlow_ff};
   assign hi_th = {target_ff[SW-1], target_ff} + {2'b00, hyst_ff};
   assign lo_th = {target_ff[SW-1], target_ff} - {2'b00, hyst_ff};
   assign dq    = drsp.quotient;
   assign dq_sat = (dq[63:32] != '0) ? 32'hFFFF_FFFF : dq[31:0];

   always_comb begin
      unique case (avg_ff)
         2'd0: tsel = kpt_ff;
         2'd1: tsel = kit_ff;
         default: tsel = kdt_ff;
      endcase
   end

   always_comb begin
      st_in = st_ff; run_in = run_ff; relay_in = relay_ff; last_in = last_ff;
      pkh_in = pkh_ff; pkl_in = pkl_ff; cyc_in = cyc_ff; smp_in = smp_ff;
      kpt_in = kpt_ff; kit_in = kit_ff; kdt_in = kdt_ff;
      func_in = func_ff; s_in = s_ff; now_in = now_ff; el_in = el_ff; amp_in = amp_ff;
      kp_in = kp_ff; ki_in = ki_ff; kd_in = kd_ff; q_in = q_ff; add_in = add_ff;
      avg_in = avg_ff; gv_in = gv_ff; gkp_in = gkp_ff; gki_in = gki_ff; gkd_in = gkd_ff;
      drv_in = drv_ff; ov_in = ov_ff;
      dreq = '0;
      prod = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in = req_tuser;
               s_in    = req_tdata[SW-1:0];
               now_in  = req_tdata[SW+31:SW];
               gv_in = 1'b0; gkp_in = '0; gki_in = '0; gkd_in = '0;
               st_in = S_EVAL;
            end
         end
         S_EVAL: begin
            drv_in = '0;
            st_in  = S_OUT;
            if (func_ff) begin
               cyc_in = '0; smp_in = '0; kpt_in = '0; kit_in = '0; kdt_in = '0;
               pkh_in = {1'b1, {(SW-1){1'b0}}};
               pkl_in = {1'b0, {(SW-1){1'b1}}};
               run_in = ST_TUNING; relay_in = 1'b1; last_in = now_ff;
               drv_in = dhigh_ff;
            end else if (run_ff == ST_TUNING) begin
               if ((now_ff - last_ff) > tlim_ff) begin
                  run_in = ST_TIMEOUT;
               end else begin
                  if (s_ff > pkh_ff) pkh_in = s_ff;
                  if (s_ff < pkl_ff) pkl_in = s_ff;
                  drv_in = relay_ff ? dhigh_ff : dlow_ff;
                  if (relay_ff && (s_ff > hi_th)) begin
                     relay_in = 1'b0;
                     drv_in   = dlow_ff;
                  end else if (!relay_ff && (s_ff < lo_th)) begin
                     el_in = now_ff - last_ff;
                     last_in = now_ff;
                     relay_in = 1'b1;
                     drv_in = dhigh_ff;
                     // use updated peaks
                     amp_in = {pkh_in[SW-1], pkh_in} - {pkl_in[SW-1], pkl_in};
                     add_in = (pkh_in > pkl_in) && (cyc_ff != 8'd0);
                     kp_in = '0; ki_in = '0; kd_in = '0;
                     if ((pkh_in > pkl_in) && !span[SW] && (span != '0))
                        st_in = S_KP;
                     else
                        st_in = S_ACC;
                  end
               end
            end
         end
         S_KP: begin
            prod = 64'({{(40-SW-1){1'b0}}, span} * {16'd0, rule_kc(rule_ff)});
            dreq.start = 1'b1;
            dreq.dividend = prod;
            dreq.divisor = 40'(amp_ff);
            st_in = S_KPW;
         end
         S_KPW: if (drsp.done) begin
            prod = dq >> SHIFT;
            kp_in = (prod[63:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];
            if (prod == '0) st_in = S_ACC;
            else if (el_ff == '0) begin
               ki_in = 32'hFFFF_FFFF; st_in = S_KD;
            end else st_in = S_KI;
         end
         S_KI: begin
            dreq.start = 1'b1;
            dreq.dividend = 64'(kp_ff) * 64'(rule_ki(rule_ff));
            dreq.divisor = 40'(el_ff);
            st_in = S_KIW;
         end
         S_KIW: if (drsp.done) begin
            ki_in = dq_sat; st_in = S_KD;
         end
         S_KD: begin
            dreq.start = 1'b1;
            dreq.dividend = 64'(kp_ff) * 64'(el_ff);
            dreq.divisor = 40'(rule_tdd(rule_ff));
            st_in = S_KDW;
         end
         S_KDW: if (drsp.done) begin
            if (dq[63:32] != '0) begin
               kd_in = 32'hFFFF_FFFF; st_in = S_ACC;
            end else begin
               q_in = dq[31:0];
               // remainder term numerator
               el_in = drsp.remainder[31:0];
               st_in = S_KR;
            end
         end
         S_KR: begin
            dreq.start = 1'b1;
            dreq.dividend = 64'(el_ff) * 64'(rule_tdn(rule_ff));
            dreq.divisor = 40'(rule_tdd(rule_ff));
            q_in = 32'(q_ff) ;
            prod = 64'(q_ff) * 64'(rule_tdn(rule_ff));
            kd_in = prod[31:0];
            ov_in = prod[63:32] != '0;
            st_in = S_KRW;
         end
         S_KRW: if (drsp.done) begin
            prod = {32'd0, kd_ff} + dq;
            kd_in = (ov_ff || prod[63:32] != '0) ? 32'hFFFF_FFFF : prod[31:0];
            st_in = S_ACC;
         end
         S_ACC: begin
            if (add_ff) begin
               kpt_in = kpt_ff + 40'(kp_ff);
               kit_in = kit_ff + 40'(ki_ff);
               kdt_in = kdt_ff + 40'(kd_ff);
               if (smp_ff != 8'd255) smp_in = smp_ff + 8'd1;
            end
            pkh_in = {1'b1, {(SW-1){1'b0}}};
            pkl_in = {1'b0, {(SW-1){1'b1}}};
            st_in = S_OUT;
            if (cyc_ff != 8'd255) cyc_in = cyc_ff + 8'd1;
            if (((cyc_ff != 8'd255) ? cyc_ff + 8'd1 : cyc_ff) >= cycw_ff) begin
               run_in = ST_DONE;
               avg_in = 2'd0;
               if ((add_ff && smp_ff != 8'd255 ? smp_ff + 8'd1 : smp_ff) != 8'd0)
                  st_in = S_AVG;
            end
         end
         S_AVG: begin
            dreq.start = 1'b1;
            dreq.dividend = 64'(tsel);
            dreq.divisor = 40'(smp_ff);
            st_in = S_AVGW;
         end
         S_AVGW: if (drsp.done) begin
            unique case (avg_ff)
               2'd0: gkp_in = dq[31:0];
               2'd1: gki_in = dq[31:0];
               default: gkd_in = dq[31:0];
            endcase
            if (avg_ff == 2'd2) begin
               gv_in = 1'b1; st_in = S_OUT;
            end else begin
               avg_in = avg_ff + 2'd1; st_in = S_AVG;
            end
         end
         S_OUT: if (rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; run_ff <= ST_IDLE; relay_ff <= 1'b1; last_ff <= '0;
         pkh_ff <= {1'b1, {(SW-1){1'b0}}}; pkl_ff <= {1'b0, {(SW-1){1'b1}}};
         cyc_ff <= '0; smp_ff <= '0; kpt_ff <= '0; kit_ff <= '0; kdt_ff <= '0;
      end else begin
         st_ff <= st_in; run_ff <= run_in; relay_ff <= relay_in; last_ff <= last_in;
         pkh_ff <= pkh_in; pkl_ff <= pkl_in; cyc_ff <= cyc_in; smp_ff <= smp_in;
         kpt_ff <= kpt_in; kit_ff <= kit_in; kdt_ff <= kdt_in;
      end
      func_ff <= func_in; s_ff <= s_in; now_ff <= now_in; el_ff <= el_in; amp_ff <= amp_in;
      kp_ff <= kp_in; ki_ff <= ki_in; kd_ff <= kd_in; q_ff <= q_in; add_ff <= add_in;
      avg_ff <= avg_in; gv_ff <= gv_in; gkp_ff <= gkp_in; gki_ff <= gki_in;
      gkd_ff <= gkd_in; drv_ff <= drv_in; ov_ff <= ov_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT);
   assign rsp_tdata  = RSP_W'({gkd_ff, gki_ff, gkp_ff, gv_ff, run_ff, drv_ff});

`ifndef SYNTHESIS
   a_gv_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && gv_ff |-> run_ff == ST_DONE) else $error("gains without done");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("overlap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("rsp dropped");
`endif

endmodule

>>> test/relay_feedback_pid_autotuner_test.sv
// self-checking testbench for the relay feedback pid autotuner
// drives start and sample beats, predicts every rsp beat, checks field by field
// depends on rfat_pkg and the relay_feedback_pid_autotuner rtl
`timescale 1ns / 1ps

module relay_feedback_pid_autotuner_test
   import rfat_pkg::*;
();

   // one req beat
   typedef struct {
      bit                 start;
      logic signed [15:0] sample;
      logic [31:0]        stamp;
   } tune_beat_type;

   // one rsp beat
   typedef struct {
      logic [15:0] drive;
      logic [1:0]  status;
      logic        gains_valid;
      logic [31:0] kp;
      logic [31:0] ki;
      logic [31:0] kd;
   } gain_report_type;

   localparam longint unsigned GainSat  = 64'hFFFF_FFFF;
   localparam longint unsigned TotMask  = 64'hFF_FFFF_FFFF;
   localparam int              IdleLimit = 20000;
   localparam int              ItemGoal  = 1850;

   // per-rule factors: 4/pi*c in q.24, 1000/ti, td/1000 as a fraction
   localparam longint unsigned KC_TAB [4] = '{12816849, 14952990, 7049267, 4272283};
   localparam longint unsigned KI_TAB [4] = '{2000, 2500, 2000, 2000};
   localparam longint unsigned TDN_TAB[4] = '{1, 3, 33, 33};
   localparam longint unsigned TDD_TAB[4] = '{8000, 20000, 100000, 100000};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;   // sample(16), time_ms(32)
   logic         req_tuser;   // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;   // drive(16), status(2), gains_valid, kp, ki, kd, zero pad
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   relay_feedback_pid_autotuner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   tune_beat_type   beat_q[$];     // beats waiting for the driver
   gain_report_type report_q[$];   // predicted rsp beats, oldest first
   int              errors;
   int              item_count;

   // configuration as the predictor sees it
   int          cfg_target;
   int          cfg_hyst;
   int          cfg_dhigh;
   int          cfg_dlow;
   int          cfg_rule;
   int          cfg_cycles;
   logic [31:0] cfg_timeout;

   // predictor copy of the tuner state
   logic [1:0]      mdl_status;
   bit              mdl_relay_high;
   logic [31:0]     mdl_last_switch;
   int              mdl_peak_hi;
   int              mdl_peak_lo;
   int              mdl_cycles;
   int              mdl_gain_count;
   longint unsigned mdl_kp_sum;
   longint unsigned mdl_ki_sum;
   longint unsigned mdl_kd_sum;

   // per-cycle gains from drive span, sample amplitude and period
   task automatic cycle_gain_calc(input longint unsigned amp, input logic [31:0] period,
                                  output longint unsigned kp, output longint unsigned ki,
                                  output longint unsigned kd);
      int              span;
      longint unsigned p;
      longint unsigned t;
      longint unsigned q;
      longint unsigned r;
      span = cfg_dhigh - cfg_dlow;
      kp = 0;
      ki = 0;
      kd = 0;
      if (span > 0) begin
         p = (longint'(span) * KC_TAB[cfg_rule]) / amp;
         p = p >> (24 - 16);
         if (p > GainSat) p = GainSat;
         kp = p;
         if (p != 0) begin
            if (period == 0) begin
               ki = GainSat;
            end else begin
               t = (p * KI_TAB[cfg_rule]) / longint'(period);
               ki = (t > GainSat) ? GainSat : t;
            end
            t = p * longint'(period);
            q = t / TDD_TAB[cfg_rule];
            r = t % TDD_TAB[cfg_rule];
            if (q > GainSat) begin
               kd = GainSat;
            end else begin
               t = q * TDN_TAB[cfg_rule] + (r * TDN_TAB[cfg_rule]) / TDD_TAB[cfg_rule];
               kd = (t > GainSat) ? GainSat : t;
            end
         end
      end
   endtask

   // advance the predictor by one accepted beat and queue what it must return
   task automatic predict_report(input tune_beat_type b);
      gain_report_type rep;
      int              s;
      int              drv;
      logic [31:0]     gap;
      longint unsigned kp;
      longint unsigned ki;
      longint unsigned kd;
      s = int'(b.sample);
      drv = 0;
      rep.gains_valid = 1'b0;
      rep.kp = '0;
      rep.ki = '0;
      rep.kd = '0;
      if (b.start) begin
         mdl_cycles = 0;
         mdl_gain_count = 0;
         mdl_kp_sum = 0;
         mdl_ki_sum = 0;
         mdl_kd_sum = 0;
         mdl_peak_hi = -32768;
         mdl_peak_lo = 32767;
         mdl_status = ST_TUNING;
         mdl_relay_high = 1'b1;
         mdl_last_switch = b.stamp;
         drv = cfg_dhigh;
      end else if (mdl_status == ST_TUNING) begin
         gap = b.stamp - mdl_last_switch;
         if (gap > cfg_timeout) begin
            mdl_status = ST_TIMEOUT;
         end else begin
            if (s > mdl_peak_hi) mdl_peak_hi = s;
            if (s < mdl_peak_lo) mdl_peak_lo = s;
            if (mdl_relay_high && s > cfg_target + cfg_hyst) begin
               mdl_relay_high = 1'b0;
            end else if (!mdl_relay_high && s < cfg_target - cfg_hyst) begin
               // low-to-high switch closes one oscillation cycle
               mdl_last_switch = b.stamp;
               mdl_relay_high = 1'b1;
               if (mdl_peak_hi > mdl_peak_lo) begin
                  cycle_gain_calc(longint'(mdl_peak_hi - mdl_peak_lo), gap, kp, ki, kd);
                  // first cycle only settles the loop
                  if (mdl_cycles > 0) begin
                     mdl_kp_sum = (mdl_kp_sum + kp) & TotMask;
                     mdl_ki_sum = (mdl_ki_sum + ki) & TotMask;
                     mdl_kd_sum = (mdl_kd_sum + kd) & TotMask;
                     if (mdl_gain_count < 255) mdl_gain_count++;
                  end
               end
               mdl_peak_hi = -32768;
               mdl_peak_lo = 32767;
               if (mdl_cycles < 255) mdl_cycles++;
               if (mdl_cycles >= cfg_cycles) begin
                  if (mdl_gain_count > 0) begin
                     rep.kp = mdl_kp_sum / mdl_gain_count;
                     rep.ki = mdl_ki_sum / mdl_gain_count;
                     rep.kd = mdl_kd_sum / mdl_gain_count;
                     rep.gains_valid = 1'b1;
                  end
                  mdl_status = ST_DONE;
               end
            end
            drv = mdl_relay_high ? cfg_dhigh : cfg_dlow;
         end
      end
      rep.drive = drv[15:0];
      rep.status = mdl_status;
      report_q.push_back(rep);
   endtask

   // ---------------- req driver ----------------
   int req_wait;
   int req_beats;
   bit req_calm;

   always @(posedge clock) begin
      bit            next_valid;
      tune_beat_type nb;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
         req_beats = 0;
         req_calm = 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            nb.start = req_tuser;
            nb.sample = req_tdata[15:0];
            nb.stamp = req_tdata[47:16];
            predict_report(nb);
            next_valid = 1'b0;
            req_beats++;
            // stretches of back-to-back beats now and then
            if (req_beats % 64 == 0) req_calm = ($urandom_range(0, 2) == 0);
            req_wait = req_calm ? 0 : $urandom_range(0, 3);
         end
         if (!next_valid) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (beat_q.size() > 0) begin
               nb = beat_q.pop_front();
               req_tuser <= nb.start;
               req_tdata <= {nb.stamp, nb.sample};
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // ---------------- rsp monitor ----------------
   int rsp_stall;
   int rsp_beats;
   bit rsp_calm;

   always @(posedge clock) begin
      gain_report_type want;
      bit              next_ready;
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_stall = 0;
         rsp_beats = 0;
         rsp_calm = 1'b0;
      end else begin
         next_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            rsp_beats++;
            if (report_q.size() == 0) begin
               $display("%0t: unexpected rsp beat, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = report_q.pop_front();
               if (rsp_tdata[15:0] !== want.drive) begin
                  $display("%0t: drive expected %h actual %h", $time, want.drive,
                           rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[17:16] !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_tdata[17:16]);
                  errors++;
               end
               if (rsp_tdata[18] !== want.gains_valid) begin
                  $display("%0t: gains_valid expected %0d actual %0d", $time,
                           want.gains_valid, rsp_tdata[18]);
                  errors++;
               end
               if (rsp_tdata[50:19] !== want.kp) begin
                  $display("%0t: kp expected %h actual %h", $time, want.kp, rsp_tdata[50:19]);
                  errors++;
               end
               if (rsp_tdata[82:51] !== want.ki) begin
                  $display("%0t: ki expected %h actual %h", $time, want.ki, rsp_tdata[82:51]);
                  errors++;
               end
               if (rsp_tdata[114:83] !== want.kd) begin
                  $display("%0t: kd expected %h actual %h", $time, want.kd,
                           rsp_tdata[114:83]);
                  errors++;
               end
            end
            if (rsp_beats % 64 == 0) rsp_calm = ($urandom_range(0, 2) == 0);
            // one long hold-off so the block backs up into req
            rsp_stall = (rsp_beats == 400) ? 300 : (rsp_calm ? 0 : $urandom_range(0, 3));
            next_ready = (rsp_stall == 0);
         end else if (!rsp_tready) begin
            if (rsp_stall > 0) rsp_stall--;
            next_ready = (rsp_stall == 0);
         end
         rsp_tready <= next_ready;
      end
   end

   // ---------------- watchdog ----------------
   int idle_cycles;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (beat_q.size() == 0 && report_q.size() == 0 && !req_tvalid)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TARGET:  cfg_target = int'($signed(val[15:0]));
         CSR_HYST:    cfg_hyst = int'(val[14:0]);
         CSR_DHIGH:   cfg_dhigh = int'($signed(val[15:0]));
         CSR_DLOW:    cfg_dlow = int'($signed(val[15:0]));
         CSR_RULE:    cfg_rule = int'(val[1:0]);
         CSR_CYCLES:  cfg_cycles = int'(val[7:0]);
         default:     cfg_timeout = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input int tgt, input int hyst, input int dh, input int dl,
                             input int rule, input int cyc, input logic [31:0] tmo);
      csr_write(CSR_TARGET, tgt);
      csr_write(CSR_HYST, hyst);
      csr_write(CSR_DHIGH, dh);
      csr_write(CSR_DLOW, dl);
      csr_write(CSR_RULE, rule);
      csr_write(CSR_CYCLES, cyc);
      csr_write(CSR_TIMEOUT, tmo);
   endtask

   task automatic add_beat(input bit st, input int s, input logic [31:0] t);
      tune_beat_type b;
      b.start = st;
      b.sample = s[15:0];
      b.stamp = t;
      beat_q.push_back(b);
      item_count++;
   endtask

   // sender pause: hold off until every predicted rsp beat has arrived
   // checked between edges so a beat just taken from the queue is still seen
   task automatic drain;
      do @(negedge clock);
      while (beat_q.size() != 0 || report_q.size() != 0 || req_tvalid);
      repeat (10) @(posedge clock);
   endtask

   // oscillation runs with random amplitudes, periods and some noise, now and then a stray beat
   task automatic oscillate(input int runs, input int cyc, input int dt_max);
      int          hi;
      int          lo;
      int          n;
      int          j;
      int          k;
      logic [31:0] now;
      hi = cfg_target + cfg_hyst;
      lo = cfg_target - cfg_hyst;
      now = $urandom;
      for (n = 0; n < runs; n++) begin
         add_beat(1'b1, $urandom, now);
         for (k = 0; k <= cyc; k++) begin
            for (j = $urandom_range(0, 2); j > 0; j--) begin
               now += $urandom_range(0, dt_max);
               add_beat(1'b0, cfg_target + $urandom_range(0, 2 * cfg_hyst) - cfg_hyst, now);
            end
            now += $urandom_range(0, dt_max);
            add_beat(1'b0, (hi < 32767) ? hi + 1 + $urandom_range(0, 32766 - hi) : $urandom,
                     now);
            if ($urandom_range(0, 9) == 0) begin
               now += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, dt_max);
               add_beat($urandom_range(0, 19) == 0, $urandom, now);
            end
            now += $urandom_range(0, dt_max);
            add_beat(1'b0, (lo > -32768) ? lo - 1 - $urandom_range(0, lo + 32767) : $urandom,
                     now);
         end
      end
   endtask

   initial begin
      bit big_done;
      int dh;
      errors = 0;
      item_count = 0;
      big_done = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_TARGET;
      csr_wdata = '0;
      // reset values of the configuration
      cfg_target = 0;
      cfg_hyst = 0;
      cfg_dhigh = 0;
      cfg_dlow = 0;
      cfg_rule = 0;
      cfg_cycles = 1;
      cfg_timeout = '1;
      mdl_status = ST_IDLE;
      mdl_relay_high = 1'b1;
      mdl_last_switch = '0;
      mdl_peak_hi = -32768;
      mdl_peak_lo = 32767;
      mdl_cycles = 0;
      mdl_gain_count = 0;
      mdl_kp_sum = 0;
      mdl_ki_sum = 0;
      mdl_kd_sum = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: samples while idle, then a run on reset config (zero drive span)
      add_beat(1'b0, 32767, 32'd5);
      add_beat(1'b0, -32768, 32'hFFFF_FFFF);
      add_beat(1'b1, 0, 32'd100);
      add_beat(1'b0, 5, 32'd110);
      add_beat(1'b0, -5, 32'd120);
      drain();

      // extreme drive span, zero periods, one settling cycle and then one gain sample
      set_config(0, 0, 32767, -32768, 0, 2, 32'hFFFF_FFFF);
      add_beat(1'b1, 0, 32'hFFFF_FFF0);
      add_beat(1'b0, 32767, 32'hFFFF_FFF0);
      add_beat(1'b0, -32768, 32'hFFFF_FFF0);
      add_beat(1'b0, 1, 32'hFFFF_FFF0);
      add_beat(1'b0, -1, 32'hFFFF_FFF0);
      add_beat(1'b0, 3, 32'h5);
      drain();

      // timeout with a zero limit, then a run with cycles zero that never switches and times out
      set_config(-32768, 32767, -32768, 32767, 3, 0, 32'd0);
      add_beat(1'b1, 0, 32'd0);
      add_beat(1'b0, 0, 32'd0);
      add_beat(1'b0, 0, 32'd1);
      drain();
      set_config(32767, 0, 100, -100, 1, 0, 32'd1000);
      add_beat(1'b1, 0, 32'd0);
      add_beat(1'b0, 32767, 32'd10);
      add_beat(1'b0, 32766, 32'd20);
      add_beat(1'b0, 32766, 32'd20);
      add_beat(1'b0, -32768, 32'd2000);
      drain();

      // random phases
      while (item_count < ItemGoal) begin
         dh = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 32767) : -$urandom_range(0, 32768);
         set_config(($urandom_range(0, 4) < 3) ? $urandom_range(0, 2000) - 1000 :
                        int'($signed(16'($urandom))),
                    ($urandom_range(0, 9) < 7) ? $urandom_range(0, 500) : $urandom_range(0, 32767),
                    dh,
                    ($urandom_range(0, 4) != 0) ? dh - $urandom_range(0, dh + 32768) :
                        int'($signed(16'($urandom))),
                    $urandom_range(0, 3),
                    (!big_done && item_count > 500) ? 255 : $urandom_range(0, 6),
                    ($urandom_range(0, 9) < 7) ? 32'hFFFF_FFFF : $urandom_range(0, 3000));
         if (cfg_cycles == 255) begin
            big_done = 1'b1;
            oscillate(1, 256, 400);
         end else begin
            oscillate($urandom_range(1, 4), cfg_cycles, ($urandom_range(0, 1) ? 50 : 2000));
         end
         drain();
      end

      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rfat_pkg.sv
rtl/core/rfat_div.sv
rtl/core/relay_feedback_pid_autotuner.sv
test/relay_feedback_pid_autotuner_test.sv
